// ===== hdl/acrfd_pkg.sv =====
// shared types, constants and helper functions for the ac remote frame decoder
// no dependencies
package acrfd_pkg;

	localparam int unsigned POS_W = 5;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned HALF_LEN = 9;

	typedef logic [7:0] byte_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [2:0] code_t;

	localparam pos_t POS_HALF = pos_t'(HALF_LEN);
	localparam pos_t POS_SUM_END = pos_t'(8);
	localparam pos_t POS_FRAME_END = pos_t'(18);
	localparam pos_t POS_LAST = pos_t'(17);
	localparam pos_t POS_MAX = pos_t'(31);

	localparam byte_t HDR_BYTE0 = 8'h4F;
	localparam byte_t HDR_BYTE1 = 8'hB0;
	localparam byte_t TEMP_ENTRIES = 8'd15;

	// fan codes
	localparam code_t FAN_AUTO = 3'd0;
	localparam code_t FAN_SPEED1 = 3'd1;
	localparam code_t FAN_SPEED2 = 3'd2;
	localparam code_t FAN_SPEED3 = 3'd3;
	localparam code_t FAN_SPEED4 = 3'd4;
	localparam code_t FAN_SPEED5 = 3'd5;
	localparam code_t FAN_UNKNOWN = 3'd6;

	// mode codes
	localparam code_t MODE_OFF = 3'd0;
	localparam code_t MODE_AUTO = 3'd1;
	localparam code_t MODE_COOL = 3'd2;
	localparam code_t MODE_DRY = 3'd3;
	localparam code_t MODE_HEAT = 3'd4;
	localparam code_t MODE_FAN = 3'd5;
	localparam code_t MODE_UNKNOWN = 3'd6;

	localparam byte_t CORR_BASE = 8'h02;
	localparam byte_t CORR_FAN = 8'h80;
	localparam byte_t CORR_HEAT = 8'hC0;

	typedef struct packed {
		logic recognized;
		code_t fan_speed;
		code_t mode;
		logic [4:0] temperature;
		logic temperature_known;
		byte_t computed_checksum;
		byte_t received_checksum;
		logic checksum_ok;
	} acrfd_result_t;

	function automatic byte_t rev8(input byte_t v);
		byte_t r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	function automatic logic [4:0] temp_lookup(input idx_t idx);
		logic [4:0] t;
		unique case (idx)
			4'd0: t = 5'd17;
			4'd1: t = 5'd25;
			4'd2: t = 5'd21;
			4'd3: t = 5'd29;
			4'd4: t = 5'd19;
			4'd5: t = 5'd27;
			4'd6: t = 5'd23;
			4'd7: t = 5'd0;
			4'd8: t = 5'd18;
			4'd9: t = 5'd26;
			4'd10: t = 5'd22;
			4'd11: t = 5'd30;
			4'd12: t = 5'd20;
			4'd13: t = 5'd28;
			4'd14: t = 5'd24;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== hdl/acrfd_decode.sv =====
// field decode and checksum correction for a completed frame
// depends on acrfd_pkg
module acrfd_decode (
	input  logic                   recognized,
	input  acrfd_pkg::byte_t       temp_byte,
	input  acrfd_pkg::byte_t       ctrl_byte,
	input  acrfd_pkg::byte_t       chk_byte,
	input  acrfd_pkg::byte_t       sum,
	output acrfd_pkg::acrfd_result_t result
);
	import acrfd_pkg::*;

	logic [3:0] lo;
	logic [3:0] hi;
	code_t fan;
	code_t md;
	byte_t corr;
	byte_t chk;
	logic temp_known;

	assign lo = ctrl_byte[3:0];
	assign hi = ctrl_byte[7:4];

	always_comb begin
		unique case (lo)
			4'h0: fan = FAN_AUTO;
			4'h2: fan = FAN_SPEED1;
			4'h6: fan = FAN_SPEED2;
			4'h1: fan = FAN_SPEED3;
			4'h5: fan = FAN_SPEED4;
			4'h3: fan = FAN_SPEED5;
			default: fan = FAN_UNKNOWN;
		endcase
	end

	always_comb begin
		unique case (hi)
			4'hE: md = MODE_OFF;
			4'h0: md = MODE_AUTO;
			4'h8: md = MODE_COOL;
			4'h4: md = MODE_DRY;
			4'hC: md = MODE_HEAT;
			4'h2: md = MODE_FAN;
			default: md = MODE_UNKNOWN;
		endcase
	end

	always_comb begin
		corr = '0;
		priority if (md == MODE_AUTO || md == MODE_FAN) begin
			corr = CORR_BASE;
			if (lo == 4'h2 || lo == 4'h3 || lo == 4'h6) begin
				corr = CORR_BASE + CORR_FAN;
			end
		end else if (md == MODE_DRY) begin
			corr = CORR_BASE;
		end else if (md == MODE_HEAT) begin
			if (lo == 4'h5 || lo == 4'h6) begin
				corr = CORR_HEAT;
			end
		end else begin
			corr = '0;
		end
	end

	assign chk = rev8(sum + corr);
	assign temp_known = temp_byte < TEMP_ENTRIES;

	always_comb begin
		result = '0;
		if (recognized) begin
			result.recognized = 1'b1;
			result.fan_speed = fan;
			result.mode = md;
			result.temperature_known = temp_known;
			result.temperature = temp_known ? temp_lookup(temp_byte[IDX_W-1:0]) : 5'd0;
			result.computed_checksum = chk;
			result.received_checksum = chk_byte;
			result.checksum_ok = (chk == chk_byte);
		end
	end

endmodule

// ===== hdl/ac_remote_frame_decoder.sv =====
// ac remote frame decoder: one byte per transaction, result on the end-of-frame byte
// result path: the end-of-frame byte passes the input register, then the decoded result is registered in the result reg
// throughput: one byte per cycle; an end-of-frame byte waits while an unaccepted result is held
// reset: arst_n clears frame position, running sum, mismatch flag and both valids
// the first-half byte store has no reset; a frame writes it before any read
// depends on acrfd_pkg and acrfd_decode
module ac_remote_frame_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  acrfd_pkg::byte_t       frame_byte,
	input  logic                   end_of_frame,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   recognized,
	output logic [2:0]             fan_speed,
	output logic [2:0]             mode,
	output logic [4:0]             temperature,
	output logic                   temperature_known,
	output acrfd_pkg::byte_t       computed_checksum,
	output acrfd_pkg::byte_t       received_checksum,
	output logic                   checksum_ok
);
	import acrfd_pkg::*;

	logic valid_s1;
	byte_t byte_s1;
	logic eof_s1;

	pos_t pos_q;
	byte_t sum_q;
	logic differ_q;
	byte_t store_q [HALF_LEN];

	logic out_valid_q;
	acrfd_result_t result_q;

	logic out_free;
	logic advance;
	logic in_first;
	logic in_second;
	logic in_sum;
	pos_t cmp_pos;
	logic mismatch;
	logic differ_now;
	byte_t sum_now;
	logic frame_ok;
	acrfd_result_t result_d;

	assign out_free = !out_valid_q || out_ready;
	assign advance = valid_s1 && (!eof_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	assign in_first = pos_q < POS_HALF;
	assign in_second = !in_first && (pos_q < POS_FRAME_END);
	assign in_sum = pos_q < POS_SUM_END;
	assign cmp_pos = pos_q - POS_HALF;
	assign mismatch = in_second && (store_q[cmp_pos[IDX_W-1:0]] != byte_s1);
	assign differ_now = differ_q || mismatch;
	assign sum_now = in_sum ? sum_q + rev8(byte_s1) : sum_q;
	assign frame_ok = (pos_q == POS_LAST) && !differ_now &&
		(store_q[0] == HDR_BYTE0) && (store_q[1] == HDR_BYTE1);

	acrfd_decode u_decode (
		.recognized (frame_ok),
		.temp_byte  (store_q[5]),
		.ctrl_byte  (store_q[6]),
		.chk_byte   (store_q[8]),
		.sum        (sum_q),
		.result     (result_d)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= frame_byte;
			eof_s1 <= end_of_frame;
		end
	end

	// per-frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			differ_q <= 1'b0;
		end else if (advance) begin
			if (eof_s1) begin
				pos_q <= '0;
				sum_q <= '0;
				differ_q <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + pos_t'(1);
				end
				sum_q <= sum_now;
				differ_q <= differ_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_first) begin
			store_q[pos_q[IDX_W-1:0]] <= byte_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eof_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eof_s1) begin
			result_q <= result_d;
		end
	end

	assign out_valid = out_valid_q;
	assign recognized = result_q.recognized;
	assign fan_speed = result_q.fan_speed;
	assign mode = result_q.mode;
	assign temperature = result_q.temperature;
	assign temperature_known = result_q.temperature_known;
	assign computed_checksum = result_q.computed_checksum;
	assign received_checksum = result_q.received_checksum;
	assign checksum_ok = result_q.checksum_ok;

endmodule
